### hdl/oot_pkg.sv
package oot_pkg;

  localparam int KIND_W    = 2;
  localparam int FILE_W    = 31;
  localparam int COOKIE_W  = 31;
  localparam int PARTS_W   = 16;
  localparam int MSG_W     = 31;
  localparam int STATUS_W  = 2;
  localparam int USED_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_DUP     = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                 kind;
    logic [FILE_W-1:0]     file_id;
    logic [COOKIE_W-1:0]   cookie;
    logic [PARTS_W-1:0]    participants;
    logic [MSG_W-1:0]      reply_msg_id;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [PARTS_W-1:0]    pending_left;
    logic [MSG_W-1:0]      stored_msg_id;
    logic [USED_W-1:0]     entries_used;
  } out_t;

  typedef struct packed {
    logic [FILE_W-1:0]     file_id;
    logic [COOKIE_W-1:0]   cookie;
    logic [PARTS_W-1:0]    pending;
    logic [MSG_W-1:0]      reply;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic move;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic move_needed;
  } sts_t;

endpackage

### hdl/oot_ram.sv
module oot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/oot_ctrl.sv
module oot_ctrl import oot_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.move_needed ? S_MOVE : S_IDLE;
        end
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/oot_dpath.sv
module oot_dpath import oot_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_t                 in_data_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [CAPACITY-1:0] match_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  logic [FILE_W-1:0]   lane_file_q   [CAPACITY];
  logic [COOKIE_W-1:0] lane_cookie_q [CAPACITY];
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    cnt_m1;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    tail_idx;
  logic [CAPACITY-1:0] match;
  logic [IDX_W-1:0]    enc;
  in_t                 req_q;
  logic                hit_q;
  logic [IDX_W-1:0]    idx_q;
  entry_t              rd_entry;
  entry_t              wr_entry;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic                full;
  logic                append;
  logic                update;
  logic [PARTS_W-1:0]  dec_pending;
  logic [CNT_W-1:0]    used_cnt;
  out_t                res;
  out_t                out_q;
  logic                out_valid_q;

  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign tail_idx = cnt_q[IDX_W-1:0];
  assign full     = (cnt_q == CNT_W'(CAPACITY));

  always_comb begin
    enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CNT_W'(i) < cnt_q) && (lane_file_q[i] == in_data_i.file_id)
                 && (lane_cookie_q[i] == in_data_i.cookie);
      enc = enc | (match[i] ? IDX_W'(i) : '0);
    end
  end

  assign match_o = match;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_data_i;
      hit_q <= |match;
      idx_q <= enc;
    end
  end

  assign dec_pending = (rd_entry.pending != '0) ? rd_entry.pending - PARTS_W'(1) : '0;

  always_comb begin
    res               = '0;
    res.status        = ST_OK;
    append            = 1'b0;
    update            = 1'b0;
    used_cnt          = cnt_q;
    unique case (req_q.kind)
      KIND_START: begin
        if (hit_q) begin
          res.status        = ST_DUP;
          res.pending_left  = rd_entry.pending;
          res.stored_msg_id = rd_entry.reply;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          append            = 1'b1;
          used_cnt          = cnt_q + CNT_W'(1);
          res.pending_left  = req_q.participants;
          res.stored_msg_id = req_q.reply_msg_id;
        end
      end
      KIND_DONE: begin
        if (!hit_q) begin
          res.status = ST_MISSING;
        end else begin
          update            = 1'b1;
          res.pending_left  = dec_pending;
          res.stored_msg_id = rd_entry.reply;
        end
      end
      KIND_FREE: begin
        if (!hit_q) begin
          res.status = ST_MISSING;
        end else begin
          used_cnt          = cnt_m1;
          res.pending_left  = rd_entry.pending;
          res.stored_msg_id = rd_entry.reply;
        end
      end
      KIND_LOOKUP: begin
        if (!hit_q) begin
          res.status = ST_MISSING;
        end else begin
          res.pending_left  = rd_entry.pending;
          res.stored_msg_id = rd_entry.reply;
        end
      end
      default: begin
        res.status = ST_MISSING;
      end
    endcase
    res.entries_used = USED_W'(used_cnt);
  end

  assign sts_o.move_needed = (req_q.kind == KIND_FREE) && hit_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    wr_entry  = rd_entry;
    if (cmd_i.exec && append) begin
      ram_we            = 1'b1;
      ram_waddr         = tail_idx;
      wr_entry.file_id  = req_q.file_id;
      wr_entry.cookie   = req_q.cookie;
      wr_entry.pending  = req_q.participants;
      wr_entry.reply    = req_q.reply_msg_id;
    end else if (cmd_i.exec && update) begin
      ram_we           = 1'b1;
      wr_entry.pending = dec_pending;
    end else if (cmd_i.move) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = cmd_i.accept || (cmd_i.exec && sts_o.move_needed);
  assign ram_raddr = cmd_i.accept ? enc : last_idx;

  oot_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && append) begin
      lane_file_q[tail_idx]   <= req_q.file_id;
      lane_cookie_q[tail_idx] <= req_q.cookie;
    end else if (cmd_i.move) begin
      lane_file_q[idx_q]   <= rd_entry.file_id;
      lane_cookie_q[idx_q] <= rd_entry.cookie;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec && append) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (cmd_i.move) begin
      cnt_q <= cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/outstanding_operation_tracker.sv
// An accepted request is registered; its result is registered when it executes.
// The input stalls until then, and through a move state for a free that removes
// an entry (the entry RAM has a single read port); output stalls delay execution.
// Reset: the controller state, the entry count and the output valid flag clear at
// once; table contents are not cleared, since entries at or above the count are
// never used.
module outstanding_operation_tracker import oot_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t                cmd;
  sts_t                sts;
  logic [CAPACITY-1:0] match;

  oot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  oot_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .match_o     (match),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is still in work");

  a_unique_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> $onehot0(match))
    else $error("key matches more than one table entry");

  a_exec_needs_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> sts.out_free)
    else $error("result produced while output register is occupied");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FULL)
      |-> (out_data_o.entries_used == USED_W'(CAPACITY)))
    else $error("full status reported with table not full");

endmodule

### sim/tb_outstanding_operation_tracker.sv
module tb_outstanding_operation_tracker import oot_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int RANDOM_OPS  = 1750;
  localparam int SCRIPT_ROWS = 18;

  typedef struct packed {
    logic [FILE_W-1:0]   file_id;
    logic [COOKIE_W-1:0] cookie;
  } key_t;

  typedef struct packed {
    in_t  data;
    logic typed;
    out_t want;
  } beat_t;

  typedef struct packed {
    kind_e               kind;
    logic [FILE_W-1:0]   file_id;
    logic [COOKIE_W-1:0] cookie;
    logic [PARTS_W-1:0]  parts;
    logic [MSG_W-1:0]    reply;
    int                  reps;
    logic                typed;
    status_e             st;
    logic [PARTS_W-1:0]  pend;
    logic [MSG_W-1:0]    msg;
    int                  used;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  logic [FILE_W-1:0]   slot_file   [DEPTH];
  logic [COOKIE_W-1:0] slot_cookie [DEPTH];
  logic [PARTS_W-1:0]  slot_pend   [DEPTH];
  logic [MSG_W-1:0]    slot_reply  [DEPTH];
  int                  slots_used;
  int                  peak_used;
  int                  status_seen [4];

  beat_t op_queue[$];
  out_t  results_due[$];
  key_t  live_keys[$];
  beat_t on_bus;
  int    beats_total;
  int    beats_in;
  int    in_gap;
  int    out_gap;
  int    mismatches;

  row_t script [SCRIPT_ROWS] = '{
    '{KIND_LOOKUP, 31'd1, 31'd0, 16'd0, 31'd0, 1, 1'b1, ST_MISSING, 16'd0, 31'd0, 0},
    '{KIND_FREE, 31'd1, 31'd0, 16'd0, 31'd0, 1, 1'b1, ST_MISSING, 16'd0, 31'd0, 0},
    '{KIND_START, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF, 1, 1'b1,
      ST_OK, 16'hFFFF, 31'h7FFF_FFFF, 1},
    '{KIND_START, 31'd0, 31'd0, 16'd0, 31'd0, 1, 1'b1, ST_OK, 16'd0, 31'd0, 2},
    '{KIND_DONE, 31'd0, 31'd0, 16'd0, 31'd0, 1, 1'b1, ST_OK, 16'd0, 31'd0, 2},
    '{KIND_START, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd5, 31'd3, 1, 1'b1,
      ST_DUP, 16'hFFFF, 31'h7FFF_FFFF, 2},
    '{KIND_DONE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd0, 31'd0, 1, 1'b1,
      ST_OK, 16'hFFFE, 31'h7FFF_FFFF, 2},
    '{KIND_START, 31'h7FFF_FFFF, 31'd0, 16'd2, 31'd1, 1, 1'b1, ST_OK, 16'd2, 31'd1, 3},
    '{KIND_START, 31'd1, 31'h7FFF_FFFF, 16'd1, 31'h2AAA_AAAA, 1, 1'b1,
      ST_OK, 16'd1, 31'h2AAA_AAAA, 4},
    '{KIND_LOOKUP, 31'h7FFF_FFFF, 31'd0, 16'd0, 31'd0, 1, 1'b1, ST_OK, 16'd2, 31'd1, 4},
    '{KIND_FREE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd0, 31'd0, 1, 1'b1,
      ST_OK, 16'hFFFE, 31'h7FFF_FFFF, 3},
    '{KIND_FREE, 31'd1, 31'h7FFF_FFFF, 16'd0, 31'd0, 1, 1'b1,
      ST_OK, 16'd1, 31'h2AAA_AAAA, 2},
    '{KIND_DONE, 31'h7FFF_FFFF, 31'd0, 16'd0, 31'd0, 1, 1'b1, ST_OK, 16'd1, 31'd1, 2},
    '{KIND_START, 31'h1555_5555, 31'h100, 16'd3, 31'h5555_5555, 14, 1'b0,
      ST_OK, 16'd0, 31'd0, 0},
    '{KIND_START, 31'h1234_5678, 31'd1, 16'd7, 31'd7, 1, 1'b1, ST_FULL, 16'd0, 31'd0, 16},
    '{KIND_START, 31'd0, 31'd0, 16'd9, 31'd9, 1, 1'b1, ST_DUP, 16'd0, 31'd0, 16},
    '{KIND_FREE, 31'd0, 31'd0, 16'd0, 31'd0, 1, 1'b1, ST_OK, 16'd0, 31'd0, 15},
    '{KIND_LOOKUP, 31'd0, 31'd0, 16'd0, 31'd0, 1, 1'b1, ST_MISSING, 16'd0, 31'd0, 15}
  };

  outstanding_operation_tracker #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic out_t track_operation(in_t op);
    out_t res;
    int   hit;
    int   last;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    for (int i = slots_used - 1; i >= 0; i--) begin
      if (slot_file[i] == op.file_id && slot_cookie[i] == op.cookie) hit = i;
    end
    if (op.kind == KIND_START) begin
      if (hit >= 0) begin
        res.status = ST_DUP;
        res.pending_left = slot_pend[hit];
        res.stored_msg_id = slot_reply[hit];
      end else if (slots_used >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot_file[slots_used] = op.file_id;
        slot_cookie[slots_used] = op.cookie;
        slot_pend[slots_used] = op.participants;
        slot_reply[slots_used] = op.reply_msg_id;
        slots_used++;
        res.pending_left = op.participants;
        res.stored_msg_id = op.reply_msg_id;
      end
    end else if (hit < 0) begin
      res.status = ST_MISSING;
    end else begin
      if (op.kind == KIND_DONE && slot_pend[hit] != '0) slot_pend[hit] = slot_pend[hit] - 1'b1;
      res.pending_left = slot_pend[hit];
      res.stored_msg_id = slot_reply[hit];
      if (op.kind == KIND_FREE) begin
        last = slots_used - 1;
        slot_file[hit] = slot_file[last];
        slot_cookie[hit] = slot_cookie[last];
        slot_pend[hit] = slot_pend[last];
        slot_reply[hit] = slot_reply[last];
        slots_used = last;
      end
    end
    res.entries_used = USED_W'(slots_used);
    status_seen[res.status]++;
    if (slots_used > peak_used) peak_used = slots_used;
    return res;
  endfunction

  function automatic void note_key(in_t op);
    int hit;
    hit = -1;
    foreach (live_keys[i]) begin
      if (live_keys[i] == key_t'({op.file_id, op.cookie})) hit = i;
    end
    if (op.kind == KIND_START && hit < 0 && live_keys.size() < DEPTH) begin
      live_keys.push_back(key_t'({op.file_id, op.cookie}));
    end else if (op.kind == KIND_FREE && hit >= 0) begin
      live_keys.delete(hit);
    end
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    k.file_id = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 3)) : 31'($urandom);
    k.cookie = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 3)) : 31'($urandom);
    return k;
  endfunction

  task automatic add_random_ops(int count);
    beat_t s;
    int    goal;
    int    roll;
    int    pick;
    goal = DEPTH;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: goal = 1;
          1: goal = 4;
          2: goal = 10;
          default: goal = DEPTH;
        endcase
      end
      s = '0;
      s.data.participants = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 4));
      s.data.reply_msg_id = 31'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        s.data.kind = kind_e'($urandom_range(0, 3));
        {s.data.file_id, s.data.cookie} = fresh_key();
      end else if (live_keys.size() == 0 || roll < ((live_keys.size() < goal) ? 55 : 18)) begin
        s.data.kind = KIND_START;
        {s.data.file_id, s.data.cookie} = fresh_key();
      end else begin
        pick = $urandom_range(0, live_keys.size() - 1);
        s.data.file_id = live_keys[pick].file_id;
        s.data.cookie = live_keys[pick].cookie;
        roll = $urandom_range(0, 99);
        if (roll < ((live_keys.size() > goal) ? 45 : 15)) s.data.kind = KIND_FREE;
        else if (roll < 60) s.data.kind = KIND_DONE;
        else if (roll < 85) s.data.kind = KIND_LOOKUP;
        else s.data.kind = KIND_START;
      end
      note_key(s.data);
      op_queue.push_back(s);
    end
  endtask

  task automatic log_fault(string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : drive_and_check
    out_t got;
    out_t want;
    logic quiet;
    logic next_valid;
    logic next_stall;
    if (rst_ni) begin
      quiet = (beats_in + 150 >= beats_total) || ((beats_in / 200) % 4 == 3);
      if (in_valid_i && !in_stall_o) begin
        want = track_operation(on_bus.data);
        if (on_bus.typed) want = on_bus.want;
        results_due.push_back(want);
        beats_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (results_due.size() == 0) begin
          log_fault("result beat arrived with nothing outstanding");
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status)
            log_fault($sformatf("status got %0d, expected %0d", got.status, want.status));
          if (got.pending_left !== want.pending_left)
            log_fault($sformatf("pending_left got 0x%0h, expected 0x%0h",
                                got.pending_left, want.pending_left));
          if (got.stored_msg_id !== want.stored_msg_id)
            log_fault($sformatf("stored_msg_id got 0x%0h, expected 0x%0h",
                                got.stored_msg_id, want.stored_msg_id));
          if (got.entries_used !== want.entries_used)
            log_fault($sformatf("entries_used got %0d, expected %0d",
                                got.entries_used, want.entries_used));
        end
      end

      // A stalled beat keeps its valid and its payload.
      if (in_valid_i && in_stall_o) begin
        next_valid = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        next_valid = 1'b0;
      end else if (!quiet && op_queue.size() > 0 && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 11);
        next_valid = 1'b0;
      end else if (op_queue.size() > 0) begin
        on_bus = op_queue.pop_front();
        in_data_i <= on_bus.data;
        next_valid = 1'b1;
      end else begin
        next_valid = 1'b0;
      end
      in_valid_i <= next_valid;

      if (out_gap > 0) begin
        out_gap--;
        next_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 11);
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall_i <= next_stall;
    end
  end

  initial begin
    beat_t s;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    slots_used = 0;
    peak_used = 0;
    beats_in = 0;
    in_gap = 0;
    out_gap = 0;
    mismatches = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        s.data.kind = script[r].kind;
        s.data.file_id = script[r].file_id;
        s.data.cookie = script[r].cookie + COOKIE_W'(k);
        s.data.participants = script[r].parts;
        s.data.reply_msg_id = script[r].reply;
        s.typed = script[r].typed;
        s.want = '{script[r].st, script[r].pend, script[r].msg, USED_W'(script[r].used)};
        note_key(s.data);
        op_queue.push_back(s);
      end
    end
    add_random_ops(RANDOM_OPS);
    beats_total = op_queue.size();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (beats_in < beats_total || results_due.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d operations: %0d ok, %0d unknown key, %0d table full, %0d duplicate.",
             beats_in, status_seen[ST_OK], status_seen[ST_MISSING], status_seen[ST_FULL],
             status_seen[ST_DUP]);
    $display("Table occupancy peaked at %0d of %0d entries; %0d mismatches logged.",
             peak_used, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Run timed out with %0d results outstanding.", results_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
